### src/ascii_to_unsigned_parser_defines.svh
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASCII_TO_UNSIGNED_PARSER_DEFINES_SVH
`define ASCII_TO_UNSIGNED_PARSER_DEFINES_SVH

// Same-cycle implication.
`define AUP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication.
`define AUP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### src/aup_pkg.sv
// ----------------------------------------------------------------------------
// aup_pkg
// Types and character constants shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aup_pkg;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_ZERO   = 3'd2,
        PH_XSEEN  = 3'd3,
        PH_DIGITS = 3'd4,
        PH_IDLE   = 3'd5
    } phase_t;

    // Character classification produced for one incoming byte.
    typedef struct packed {
        logic       is_blank;
        logic       is_minus;
        logic       is_plus;
        logic       is_x;
        logic       digit_ok;
        logic [5:0] digit;
    } aup_char_t;

    typedef struct packed {
        logic done;
        logic error;
    } aup_status_t;

    localparam int RADIX_BITS = 5;

    localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 5'd0;
    localparam logic [RADIX_BITS-1:0] RADIX_MIN  = 5'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 5'd16;
    localparam logic [RADIX_BITS-1:0] BASE_OCT   = 5'd8;
    localparam logic [RADIX_BITS-1:0] BASE_DEC   = 5'd10;
    localparam logic [RADIX_BITS-1:0] BASE_HEX   = 5'd16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] LETTER_OFFSET = 8'd10;

endpackage

`default_nettype wire

### src/aup_classify.sv
// ----------------------------------------------------------------------------
// aup_classify
// Decodes one ASCII byte into blank, sign, x and digit-value flags.
// ----------------------------------------------------------------------------
`default_nettype none

module aup_classify (
    input  wire logic [7:0]        ch,
    output aup_pkg::aup_char_t     info
);

    logic [7:0] digit_wide;

    always_comb
    begin
        info.is_blank = (ch == aup_pkg::CH_SPACE) || (ch == aup_pkg::CH_TAB);
        info.is_minus = (ch == aup_pkg::CH_MINUS);
        info.is_plus  = (ch == aup_pkg::CH_PLUS);
        info.is_x     = (ch == aup_pkg::CH_LX) || (ch == aup_pkg::CH_UX);
        info.digit_ok = 1'b1;
        if (ch >= aup_pkg::CH_0 && ch <= aup_pkg::CH_9)
        begin
            digit_wide = ch - aup_pkg::CH_0;
        end
        else if (ch >= aup_pkg::CH_UA && ch <= aup_pkg::CH_UZ)
        begin
            digit_wide = ch - aup_pkg::CH_UA + aup_pkg::LETTER_OFFSET;
        end
        else if (ch >= aup_pkg::CH_LA && ch <= aup_pkg::CH_LZ)
        begin
            digit_wide = ch - aup_pkg::CH_LA + aup_pkg::LETTER_OFFSET;
        end
        else
        begin
            digit_wide    = 8'd0;
            info.digit_ok = 1'b0;
        end
        info.digit = digit_wide[5:0];
    end

endmodule

`default_nettype wire

### src/aup_core.sv
// ----------------------------------------------------------------------------
// aup_core
// Per-number parse state and the single-step update for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module aup_core #(
    parameter int VALUE_BITS = 32,
    parameter int INDEX_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              fire,
    input  wire logic                              start_req,
    input  wire aup_pkg::aup_char_t                info,
    input  wire logic [aup_pkg::RADIX_BITS-1:0]    radix,
    output logic      [VALUE_BITS-1:0]             value,
    output aup_pkg::aup_status_t                   status,
    output logic      [INDEX_BITS-1:0]             end_index
);

    localparam int RB = aup_pkg::RADIX_BITS;
    localparam int WW = VALUE_BITS + RB;

    aup_pkg::phase_t        phase_reg, phase_next, phase_e;
    logic                   neg_reg, neg_next, neg_e;
    logic [RB-1:0]          base_reg, base_next, base_e;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next, acc_e;
    logic                   err_reg, err_next, err_e;
    logic [INDEX_BITS-1:0]  cons_reg, cons_next, cons_e;
    logic [INDEX_BITS-1:0]  pos_reg, pos_next, pos_e, pos_inc;
    logic                   done;

    // Results of taking the first digit.
    aup_pkg::phase_t        f_phase;
    logic [RB-1:0]          f_base;
    logic [VALUE_BITS-1:0]  f_acc;
    logic                   f_err;
    logic [INDEX_BITS-1:0]  f_cons;
    logic                   f_done;

    // Results of taking a later digit.
    aup_pkg::phase_t        m_phase;
    logic [VALUE_BITS-1:0]  m_acc;
    logic                   m_err;
    logic [INDEX_BITS-1:0]  m_cons;
    logic                   m_done;
    logic [RB-1:0]          m_base;
    logic [WW-1:0]          m_wide;

    // A start request clears the per-number state before the character is used.
    always_comb
    begin
        if (start_req)
        begin
            phase_e = aup_pkg::PH_SKIP;
            neg_e   = 1'b0;
            base_e  = '0;
            acc_e   = '0;
            err_e   = 1'b0;
            cons_e  = '0;
            pos_e   = '0;
        end
        else
        begin
            phase_e = phase_reg;
            neg_e   = neg_reg;
            base_e  = base_reg;
            acc_e   = acc_reg;
            err_e   = err_reg;
            cons_e  = cons_reg;
            pos_e   = pos_reg;
        end
        pos_inc = (pos_e == '1) ? pos_e : pos_e + 1'b1;
    end

    always_comb
    begin
        logic [RB-1:0] r;
        logic          bad;
        f_phase = aup_pkg::PH_DIGITS;
        f_base  = base_e;
        f_acc   = acc_e;
        f_err   = err_e;
        f_cons  = pos_inc;
        f_done  = 1'b0;
        r       = radix;
        bad     = 1'b0;
        if (radix == aup_pkg::RADIX_AUTO)
        begin
            r = aup_pkg::BASE_DEC;
        end
        else if (radix < aup_pkg::RADIX_MIN || radix > aup_pkg::RADIX_MAX)
        begin
            bad = 1'b1;
        end
        if (radix == aup_pkg::RADIX_AUTO && info.digit_ok && info.digit == '0)
        begin
            f_base  = aup_pkg::BASE_OCT;
            f_acc   = '0;
            f_phase = aup_pkg::PH_ZERO;
        end
        else
        begin
            if (!bad)
            begin
                f_base = r;
            end
            if (bad || !info.digit_ok || info.digit >= {1'b0, r})
            begin
                f_err   = 1'b1;
                f_acc   = '0;
                f_cons  = '0;
                f_phase = aup_pkg::PH_IDLE;
                f_done  = 1'b1;
            end
            else
            begin
                f_acc = VALUE_BITS'(info.digit);
                if (r == aup_pkg::BASE_HEX && info.digit == '0)
                begin
                    f_phase = aup_pkg::PH_ZERO;
                end
            end
        end
    end

    // The product is wide enough that any overflow shows in its top bits.
    always_comb
    begin
        m_base  = (base_e == '0) ? aup_pkg::BASE_DEC : base_e;
        m_wide  = ({{RB{1'b0}}, acc_e} * WW'(m_base)) + WW'(info.digit);
        m_phase = aup_pkg::PH_DIGITS;
        m_acc   = acc_e;
        m_err   = err_e;
        m_cons  = pos_inc;
        m_done  = 1'b0;
        if (!info.digit_ok)
        begin
            m_phase = aup_pkg::PH_IDLE;
            m_cons  = cons_e;
            m_done  = 1'b1;
        end
        else if (!err_e)
        begin
            if (info.digit < {1'b0, m_base} && !(|m_wide[WW-1:VALUE_BITS]))
            begin
                m_acc = m_wide[VALUE_BITS-1:0];
            end
            else
            begin
                m_err = 1'b1;
                m_acc = '0;
            end
        end
    end

    // Next state.
    always_comb
    begin
        phase_next = phase_e;
        neg_next   = neg_e;
        base_next  = base_e;
        acc_next   = acc_e;
        err_next   = err_e;
        cons_next  = cons_e;
        pos_next   = pos_e;
        done       = 1'b0;
        if (phase_e != aup_pkg::PH_IDLE)
        begin
            pos_next = pos_inc;
            case (phase_e)
                aup_pkg::PH_SKIP:
                begin
                    if (info.is_blank)
                    begin
                        phase_next = aup_pkg::PH_SKIP;
                    end
                    else if (info.is_minus)
                    begin
                        neg_next   = 1'b1;
                        phase_next = aup_pkg::PH_FIRST;
                    end
                    else if (info.is_plus)
                    begin
                        phase_next = aup_pkg::PH_FIRST;
                    end
                    else
                    begin
                        phase_next = f_phase;
                        base_next  = f_base;
                        acc_next   = f_acc;
                        err_next   = f_err;
                        cons_next  = f_cons;
                        done       = f_done;
                    end
                end
                aup_pkg::PH_FIRST:
                begin
                    phase_next = f_phase;
                    base_next  = f_base;
                    acc_next   = f_acc;
                    err_next   = f_err;
                    cons_next  = f_cons;
                    done       = f_done;
                end
                aup_pkg::PH_ZERO:
                begin
                    if (info.is_x)
                    begin
                        base_next  = aup_pkg::BASE_HEX;
                        phase_next = aup_pkg::PH_XSEEN;
                    end
                    else
                    begin
                        phase_next = m_phase;
                        acc_next   = m_acc;
                        err_next   = m_err;
                        cons_next  = m_cons;
                        done       = m_done;
                    end
                end
                aup_pkg::PH_XSEEN:
                begin
                    if (info.digit_ok && info.digit < 6'd16)
                    begin
                        acc_next   = VALUE_BITS'(info.digit);
                        cons_next  = pos_inc;
                        phase_next = aup_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        acc_next   = '0;
                        phase_next = aup_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = m_phase;
                    acc_next   = m_acc;
                    err_next   = m_err;
                    cons_next  = m_cons;
                    done       = m_done;
                end
            endcase
        end
    end

    // Result for this character, taken from the updated state.
    always_comb
    begin
        if (err_next)
        begin
            value = '0;
        end
        else if (neg_next)
        begin
            value = VALUE_BITS'(0) - acc_next;
        end
        else
        begin
            value = acc_next;
        end
        status.done  = done;
        status.error = err_next;
        end_index    = cons_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aup_pkg::PH_SKIP;
            neg_reg   <= 1'b0;
            base_reg  <= '0;
            acc_reg   <= '0;
            err_reg   <= 1'b0;
            cons_reg  <= '0;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
            cons_reg  <= cons_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

### src/ascii_to_unsigned_parser.sv
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser
// Streaming ASCII to unsigned integer converter, one character per request.
// ----------------------------------------------------------------------------
// Every character request yields one result request. The block sustains one
// character per cycle while the result side does not stall; a result is
// presented at the edge that moves its character from the input register
// into the result register, and is held there until it is taken. The
// whole parse step for a character (classification, a multiply by the base of
// at most five bits, and the overflow check) sits between those two
// registers, and the parse state is updated as the character moves forward.
// The radix register is set through the configuration channel and should only
// be written while no characters are in flight.
`default_nettype none

`include "ascii_to_unsigned_parser_defines.svh"

module ascii_to_unsigned_parser #(
    parameter int VALUE_BITS = 32,
    parameter int INDEX_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [aup_pkg::RADIX_BITS-1:0] cfg_data,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     ch,
    input  wire logic                           start_req,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [VALUE_BITS-1:0]          value,
    output logic                                done_res,
    output logic                                error,
    output logic      [INDEX_BITS-1:0]          end_index
);

    logic [aup_pkg::RADIX_BITS-1:0] radix_reg;

    logic                   in1_valid_reg, in1_valid_next;
    logic [7:0]             ch_reg;
    logic                   start_reg;
    logic                   advance;

    aup_pkg::aup_char_t     info;
    aup_pkg::aup_status_t   step_status;
    logic [VALUE_BITS-1:0]  step_value;
    logic [INDEX_BITS-1:0]  step_index;

    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]  value_reg;
    aup_pkg::aup_status_t   status_reg;
    logic [INDEX_BITS-1:0]  index_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= aup_pkg::RADIX_AUTO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radix_reg <= cfg_data;
        end
    end

    // The held character moves on whenever the result register is free.
    assign advance        = in1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in1_valid_reg && !advance;
    assign in1_valid_next = (in_valid && !in_stall) || (in1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in1_valid_reg <= in1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ch_reg    <= ch;
            start_reg <= start_req;
        end
        if (advance)
        begin
            value_reg  <= step_value;
            status_reg <= step_status;
            index_reg  <= step_index;
        end
    end

    aup_classify u_classify (
        .ch   (ch_reg),
        .info (info)
    );

    aup_core #(
        .VALUE_BITS (VALUE_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .start_req (start_reg),
        .info      (info),
        .radix     (radix_reg),
        .value     (step_value),
        .status    (step_status),
        .end_index (step_index)
    );

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign done_res  = status_reg.done;
    assign error     = status_reg.error;
    assign end_index = index_reg;

    `AUP_ASSERT_IMPL(a_err_zero_value, out_valid_reg && status_reg.error, value_reg == '0)
    `AUP_ASSERT_IMPL(a_ok_end_has_index,
        out_valid_reg && status_reg.done && !status_reg.error, index_reg != '0)
    `AUP_ASSERT_IMPL(a_stall_only_when_full, in_stall, in1_valid_reg && out_valid_reg)
    `AUP_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg)

endmodule

`default_nettype wire

### test/aup_parse_checker.sv
// ----------------------------------------------------------------------------
// aup_parse_checker
// Watches the radix, character and result channels of the ASCII to unsigned
// parser. It keeps its own copy of the parse state, predicts the result of
// every accepted character, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module aup_parse_checker #(
    parameter int VALUE_BITS = 32,
    parameter int INDEX_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [aup_pkg::RADIX_BITS-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [7:0]                     ch,
    input  logic                           start_req,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [VALUE_BITS-1:0]          value,
    input  logic                           done_res,
    input  logic                           error,
    input  logic [INDEX_BITS-1:0]          end_index,
    output int                             mismatches,
    output int                             outstanding
);
    import aup_pkg::*;

    localparam logic [7:0] NO_DIGIT = 8'hFF;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  done;
        logic                  error;
        logic [INDEX_BITS-1:0] end_index;
    } conversion_t;

    conversion_t conversion_q[$];

    // Parse state, mirrored from what the block should hold.
    logic [RADIX_BITS-1:0] radix_r;
    phase_t                ph;
    logic                  neg;
    logic [RADIX_BITS-1:0] base_r;
    logic [VALUE_BITS-1:0] acc;
    logic                  bad;
    logic [INDEX_BITS-1:0] used;
    logic [INDEX_BITS-1:0] pos;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return c - CH_0;
        if (c >= CH_UA && c <= CH_UZ)
            return c - CH_UA + LETTER_OFFSET;
        if (c >= CH_LA && c <= CH_LZ)
            return c - CH_LA + LETTER_OFFSET;
        return NO_DIGIT;
    endfunction

    // First character after the blanks and the sign. The radix is sampled here.
    task automatic take_lead(input logic [7:0] d, output logic ended);
        logic [RADIX_BITS-1:0] r;
        r = radix_r;
        ended = 1'b0;
        if (r == RADIX_AUTO && d == 0)
        begin
            base_r = BASE_OCT;
            acc = '0;
            used = pos;
            ph = PH_ZERO;
        end
        else
        begin
            if (r == RADIX_AUTO)
                r = BASE_DEC;
            if (r < RADIX_MIN || r > RADIX_MAX || d >= r)
            begin
                // No usable digit: the number is empty.
                bad = 1'b1;
                acc = '0;
                used = '0;
                ph = PH_IDLE;
                ended = 1'b1;
            end
            else
            begin
                base_r = r;
                acc = d;
                used = pos;
                ph = (r == BASE_HEX && d == 0) ? PH_ZERO : PH_DIGITS;
            end
        end
    endtask

    task automatic take_next(input logic [7:0] d, output logic ended);
        logic [RADIX_BITS-1:0] b;
        logic [VALUE_BITS+5:0] wide;
        ended = 1'b0;
        if (d == NO_DIGIT)
        begin
            ph = PH_IDLE;
            ended = 1'b1;
        end
        else
        begin
            if (!bad)
            begin
                b = (base_r != '0) ? base_r : BASE_DEC;
                wide = (VALUE_BITS+6)'(acc) * b + d;
                // A digit beyond the base and a carry out of the value are both sticky.
                if (d < b && wide[VALUE_BITS+5:VALUE_BITS] == '0)
                    acc = wide[VALUE_BITS-1:0];
                else
                begin
                    bad = 1'b1;
                    acc = '0;
                end
            end
            used = pos;
            ph = PH_DIGITS;
        end
    endtask

    task automatic convert_char(input logic [7:0] c, input logic s);
        logic [7:0]  d;
        logic        ended;
        conversion_t r;
        if (s)
        begin
            ph = PH_SKIP;
            neg = 1'b0;
            base_r = '0;
            acc = '0;
            bad = 1'b0;
            used = '0;
            pos = '0;
        end
        ended = 1'b0;
        if (ph != PH_IDLE)
        begin
            if (pos != '1)
                pos = pos + 1'b1;
            d = digit_value(c);
            case (ph)
                PH_SKIP:
                begin
                    if (c == CH_MINUS)
                    begin
                        neg = 1'b1;
                        ph = PH_FIRST;
                    end
                    else if (c == CH_PLUS)
                        ph = PH_FIRST;
                    else if (c != CH_SPACE && c != CH_TAB)
                        take_lead(d, ended);
                end
                PH_FIRST:
                    take_lead(d, ended);
                PH_ZERO:
                begin
                    if (c == CH_LX || c == CH_UX)
                    begin
                        base_r = BASE_HEX;
                        ph = PH_XSEEN;
                    end
                    else
                        take_next(d, ended);
                end
                PH_XSEEN:
                begin
                    if (d < BASE_HEX)
                    begin
                        acc = d;
                        used = pos;
                        ph = PH_DIGITS;
                    end
                    else
                    begin
                        // A bare 0x prefix reads as zero, ending after the '0'.
                        acc = '0;
                        ph = PH_IDLE;
                        ended = 1'b1;
                    end
                end
                default:
                    take_next(d, ended);
            endcase
        end
        r.value = bad ? '0 : (neg ? -acc : acc);
        r.done = ended;
        r.error = bad;
        r.end_index = used;
        conversion_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        conversion_t want;
        if (!rst_n)
        begin
            conversion_q.delete();
            radix_r = RADIX_AUTO;
            ph = PH_SKIP;
            neg = 1'b0;
            base_r = '0;
            acc = '0;
            bad = 1'b0;
            used = '0;
            pos = '0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                radix_r = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (conversion_q.size() == 0)
                    report("result with no request pending", value, '0);
                else
                begin
                    want = conversion_q.pop_front();
                    if (value !== want.value)
                        report("value", value, want.value);
                    if (done_res !== want.done)
                        report("done_res", done_res, want.done);
                    if (error !== want.error)
                        report("error", error, want.error);
                    if (end_index !== want.end_index)
                        report("end_index", end_index, want.end_index);
                end
            end
            if (in_valid && !in_stall)
                convert_char(ch, start_req);
        end
        outstanding = conversion_q.size();
    end

endmodule

### test/tb_ascii_to_unsigned_parser.sv
// ----------------------------------------------------------------------------
// tb_ascii_to_unsigned_parser
// Drives character strings through the parser under several radix settings
// and flow-control patterns, and leaves prediction and comparison to the
// checker beside the block.
// ----------------------------------------------------------------------------
module tb_ascii_to_unsigned_parser;
    import aup_pkg::*;

    localparam int VALUE_BITS = 32;
    localparam int INDEX_BITS = 16;
    localparam int LIMIT = 1000000;
    localparam int LONG_RUN = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [RADIX_BITS-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            ch = '0;
    logic                  start_req = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [VALUE_BITS-1:0] value;
    logic                  done_res;
    logic                  error;
    logic [INDEX_BITS-1:0] end_index;

    int mismatch_total;
    int open_results;
    int cycles = 0;
    int send_pct = 0;
    int recv_pct = 0;
    int hold_left = 0;
    int sent = 0;
    logic next_start = 1'b0;

    ascii_to_unsigned_parser #(
        .VALUE_BITS(VALUE_BITS),
        .INDEX_BITS(INDEX_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .ch(ch),
        .start_req(start_req),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .value(value),
        .done_res(done_res),
        .error(error),
        .end_index(end_index)
    );

    aup_parse_checker #(
        .VALUE_BITS(VALUE_BITS),
        .INDEX_BITS(INDEX_BITS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .ch(ch),
        .start_req(start_req),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .value(value),
        .done_res(done_res),
        .error(error),
        .end_index(end_index),
        .mismatches(mismatch_total),
        .outstanding(open_results)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: a long hold-off when asked for, random stalls otherwise.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
    end

    // Returns at the rising edge that accepted the request.
    task automatic send_char(input logic [7:0] c, input logic s);
        @(negedge clk);
        while (send_pct != 0 && $urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        start_req <= s;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic pause_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic write_radix(input logic [RADIX_BITS-1:0] r);
        pause_input();
        while (open_results != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_text(input string s, input logic lead);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], (i == 0) ? lead : 1'b0);
    endtask

    task automatic send_number_char(input logic [7:0] c);
        send_char(c, next_start);
        next_start = 1'b0;
        sent++;
    endtask

    // One number: blanks, sign, prefix, digits and a terminator, mostly
    // well formed for the radix in force, with some noise and bad digits.
    task automatic send_number(input logic [RADIX_BITS-1:0] radix);
        int b;
        int n;
        int d;
        int k;
        logic [7:0] c;
        next_start = 1'b1;
        if ($urandom_range(99) < 12)
        begin
            for (k = $urandom_range(1, 4); k > 0; k--)
                send_number_char(8'($urandom_range(255)));
        end
        else
        begin
            for (k = $urandom_range(2); k > 0; k--)
                send_number_char($urandom_range(1) ? CH_SPACE : CH_TAB);
            case ($urandom_range(2))
                0: send_number_char(CH_MINUS);
                1: send_number_char(CH_PLUS);
                default: ;
            endcase
            b = (radix >= RADIX_MIN && radix <= RADIX_MAX) ? int'(radix) : int'(BASE_DEC);
            if (radix == RADIX_AUTO)
            begin
                case ($urandom_range(2))
                    0: b = BASE_OCT;
                    1: b = BASE_DEC;
                    default: b = BASE_HEX;
                endcase
                if (b == BASE_OCT)
                    send_number_char(CH_0);
            end
            if (b == BASE_HEX && (radix == RADIX_AUTO || $urandom_range(1)))
            begin
                send_number_char(CH_0);
                send_number_char($urandom_range(1) ? CH_LX : CH_UX);
            end
            n = ($urandom_range(5) == 0) ? $urandom_range(1, 34) : $urandom_range(1, 8);
            if ($urandom_range(15) == 0)
                n = 0;
            for (k = 0; k < n; k++)
            begin
                if (k == 0 && radix == RADIX_AUTO && b == BASE_DEC)
                    d = $urandom_range(1, 9);
                else
                    d = $urandom_range(b - 1);
                if ($urandom_range(24) == 0)
                    d = $urandom_range(35);
                if (d < LETTER_OFFSET)
                    c = 8'(CH_0 + d);
                else
                    c = 8'(($urandom_range(1) ? CH_LA : CH_UA) + d - LETTER_OFFSET);
                send_number_char(c);
            end
            do
                c = 8'($urandom_range(255));
            while ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ)
                   || (c >= CH_LA && c <= CH_LZ));
            send_number_char(c);
            // Characters after the end, without a new start.
            if ($urandom_range(3) == 0)
                for (k = $urandom_range(1, 2); k > 0; k--)
                    send_char(8'($urandom_range(255)), 1'b0);
        end
    endtask

    initial
    begin : stimulus
        logic [RADIX_BITS-1:0] radix_plan[8];
        int send_plan[4];
        int recv_plan[4];
        logic [RADIX_BITS-1:0] r;
        int target;
        int k;
        logic paused;

        radix_plan = '{RADIX_AUTO, BASE_HEX, RADIX_MIN, BASE_DEC, BASE_OCT, 5'd31, 5'd1, 5'd17};
        send_plan = '{0, 57, 0, 21};
        recv_plan = '{0, 0, 57, 21};
        paused = 1'b0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, starting without a start flag after reset.
        send_text("\t-0x1f", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("0xg", 1'b1);
        send_text("+z", 1'b1);
        send_text("081 ", 1'b1);
        write_radix(BASE_HEX);
        send_text("FFFFFFFF0,", 1'b1);
        write_radix(5'd17);
        send_text("5", 1'b1);

        // One long number that overflows the value and keeps counting.
        write_radix(BASE_DEC);
        send_text("1", 1'b1);
        repeat (LONG_RUN)
            send_char(8'(CH_0 + $urandom_range(9)), 1'b0);
        send_char(CH_SPACE, 1'b0);

        for (int p = 0; p < 10; p++)
        begin
            r = (p < 8) ? radix_plan[p] : RADIX_BITS'($urandom_range(2, 16));
            write_radix(r);
            send_pct = send_plan[p % 4];
            recv_pct = recv_plan[p % 4];
            // The result side holds off while requests keep coming.
            if (p == 4)
                hold_left = 400;
            sent = 0;
            target = (r < RADIX_MIN || r > RADIX_MAX) ? 20 : 70;
            while (sent < target)
            begin
                send_number(r);
                if (p == 1 && !paused && sent >= 30)
                begin
                    pause_input();
                    while (open_results != 0)
                        @(negedge clk);
                    paused = 1'b1;
                end
            end
        end

        pause_input();
        for (k = 0; k < 5000 && open_results != 0; k++)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatch_total == 0 && open_results == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
